>>> sv/lcf_pkg.sv
// shared types and constants of the linear convolution fir
`default_nettype none
package lcf_pkg;

  localparam int TAP_IDX_W = 6;
  localparam int CFG_W     = 7;
  localparam int SUM_W     = 40;

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROT,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage : lcf_pkg
`default_nettype wire

>>> sv/lcf_cell.sv
// one ring cell: holds one tap and one sample of the window
`default_nettype none
module lcf_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lcf_pkg::cell_op_t             op,
  input  wire logic                          tap_we,
  input  wire logic signed [SAMPLE_BITS-1:0] tap_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0] shl_smp,
  input  wire logic signed [SAMPLE_BITS-1:0] rot_tap,
  input  wire logic signed [SAMPLE_BITS-1:0] rot_smp,
  output logic signed [SAMPLE_BITS-1:0]      tap_o,
  output logic signed [SAMPLE_BITS-1:0]      smp_o
);

  logic signed [SAMPLE_BITS-1:0] tap_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
      smp_r <= '0;
    end else if (tap_we) begin
      tap_r <= tap_wdata;
    end else begin
      unique case (op)
        lcf_pkg::CELL_HOLD: begin
        end
        lcf_pkg::CELL_SHIFT: begin
          smp_r <= shl_smp;
        end
        lcf_pkg::CELL_ROT: begin
          tap_r <= rot_tap;
          smp_r <= rot_smp;
        end
        lcf_pkg::CELL_CLEAR: begin
          smp_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign tap_o = tap_r;
  assign smp_o = smp_r;

endmodule : lcf_cell
`default_nettype wire

>>> sv/lcf_mac.sv
// multiply-accumulate at the head of the ring, product registered before the add
`default_nettype none
module lcf_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire lcf_pkg::mac_ctl_t             ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] tap_i,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic signed [lcf_pkg::SUM_W-1:0]   acc_o
);

  logic signed [2*SAMPLE_BITS-1:0]    prod_r;
  logic signed [lcf_pkg::SUM_W-1:0]   acc_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= tap_i * smp_i;
    end else begin
      prod_r <= '0;
    end
    // sum wraps modulo 2^SUM_W
    if (ctl.clr) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_r + lcf_pkg::SUM_W'(prod_r);
    end
  end

  assign acc_o = acc_r;

endmodule : lcf_mac
`default_nettype wire

>>> sv/linear_convolution_fir.sv
// Full linear convolution fir: a ring of tap/sample cells feeding one MAC.
// Tap load beat: accepted while idle, no result.
// Sample beat and each tail output of a flush: the cell ring makes one full turn through
// the single MAC in ST_ROT, the MAC drains in ST_DRAIN and the result loads in ST_OUT,
// where a stalled output holds it; the next beat is taken only back in ST_IDLE.
// Synchronous reset clears taps, samples and control; tap_count resets to 1.
`default_nettype none
module linear_convolution_fir #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: tap_index [5:0], value [6 +: SAMPLE_BITS], zero pad
  input  wire logic [((lcf_pkg::TAP_IDX_W+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                                  in_tuser,  // mode
  input  wire logic                                  in_tlast,  // last sample
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // out_tdata: sum [39:0]
  output logic [lcf_pkg::SUM_W-1:0]                  out_tdata,
  output logic                                       out_tlast, // final_res
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  input  wire logic                                  cfg_we,
  input  wire logic [lcf_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam logic [IDX_W-1:0] ROT_LAST = IDX_W'(MAX_TAPS - 1);

  logic [lcf_pkg::TAP_IDX_W-1:0]   in_idx;
  logic signed [SAMPLE_BITS-1:0]   in_val;

  assign in_idx = in_tdata[lcf_pkg::TAP_IDX_W-1:0];
  assign in_val = in_tdata[lcf_pkg::TAP_IDX_W +: SAMPLE_BITS];

  // configuration
  logic [lcf_pkg::CFG_W-1:0] tap_count_r;
  logic [CNT_W-1:0]          taps_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= lcf_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      tap_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = CNT_W'(1);
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(tap_count_r);
    end
  end

  // control
  lcf_pkg::state_t   state_r, state_nxt;
  logic [IDX_W-1:0]  rot_r, rot_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic              flush_r, flush_nxt;
  logic              out_valid_r;
  logic [lcf_pkg::SUM_W-1:0] out_sum_r;
  logic              out_final_r;

  lcf_pkg::cell_op_t cell_op;
  logic signed [SAMPLE_BITS-1:0] shl_in;
  logic              tap_we;
  lcf_pkg::mac_ctl_t mac_ctl;
  logic              out_load;
  logic              final_flag;
  logic signed [lcf_pkg::SUM_W-1:0] acc;

  assign final_flag = flush_r && (tail_r == '0);
  assign in_tready  = (state_r == lcf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcf_pkg::ST_IDLE;
      rot_r   <= '0;
      tail_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      tail_r  <= tail_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rot_nxt    = rot_r;
    tail_nxt   = tail_r;
    flush_nxt  = flush_r;
    cell_op    = lcf_pkg::CELL_HOLD;
    shl_in     = in_val;
    tap_we     = 1'b0;
    mac_ctl    = '0;
    out_load   = 1'b0;
    unique case (state_r)
      lcf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == lcf_pkg::MODE_TAP) begin
            tap_we = 1'b1;
          end else begin
            cell_op     = lcf_pkg::CELL_SHIFT;
            mac_ctl.clr = 1'b1;
            rot_nxt     = '0;
            flush_nxt   = in_tlast;
            tail_nxt    = taps_eff - CNT_W'(1);
            state_nxt   = lcf_pkg::ST_ROT;
          end
        end
      end
      lcf_pkg::ST_ROT: begin
        // one full turn brings every cell back to its home slot
        cell_op    = lcf_pkg::CELL_ROT;
        mac_ctl.en = (CNT_W'(rot_r) < taps_eff);
        if (rot_r == ROT_LAST) begin
          rot_nxt   = '0;
          state_nxt = lcf_pkg::ST_DRAIN;
        end else begin
          rot_nxt = rot_r + IDX_W'(1);
        end
      end
      lcf_pkg::ST_DRAIN: begin
        state_nxt = lcf_pkg::ST_OUT;
      end
      lcf_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (flush_r && (tail_r != '0)) begin
            // tail output: feed a zero sample
            tail_nxt    = tail_r - CNT_W'(1);
            cell_op     = lcf_pkg::CELL_SHIFT;
            shl_in      = '0;
            mac_ctl.clr = 1'b1;
            state_nxt   = lcf_pkg::ST_ROT;
          end else if (flush_r) begin
            cell_op   = lcf_pkg::CELL_CLEAR;
            flush_nxt = 1'b0;
            state_nxt = lcf_pkg::ST_IDLE;
          end else begin
            state_nxt = lcf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lcf_pkg::ST_IDLE;
      end
    endcase
  end

  // cell ring
  logic signed [SAMPLE_BITS-1:0] tap_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] smp_w [MAX_TAPS];

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] shl_smp;
    logic                          we;

    if (k == 0) begin : g_head
      assign shl_smp = shl_in;
    end else begin : g_body
      assign shl_smp = smp_w[k-1];
    end

    assign we = tap_we && (32'(in_idx) == k);

    lcf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op),
      .tap_we   (we),
      .tap_wdata(in_val),
      .shl_smp  (shl_smp),
      .rot_tap  (tap_w[(k+1) % MAX_TAPS]),
      .rot_smp  (smp_w[(k+1) % MAX_TAPS]),
      .tap_o    (tap_w[k]),
      .smp_o    (smp_w[k])
    );
  end

  lcf_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .tap_i(tap_w[0]),
    .smp_i(smp_w[0]),
    .acc_o(acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r   <= acc;
      out_final_r <= final_flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tlast  = out_final_r;

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && final_flag) |=>
      (state_r == lcf_pkg::ST_IDLE && smp_w[0] == '0 && smp_w[MAX_TAPS-1] == '0))
    else $error("history not cleared after final output");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (tail_r < taps_eff))
    else $error("tail count beyond active taps");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lcf_pkg::ST_IDLE) |-> !tap_we)
    else $error("tap write while ring is turning");

  a_load_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == lcf_pkg::ST_OUT && $past(state_r) == lcf_pkg::ST_DRAIN
                  || state_r == lcf_pkg::ST_OUT && $past(state_r) == lcf_pkg::ST_OUT))
    else $error("result loaded before accumulation drained");

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcf_pkg::ST_DRAIN) |-> (rot_r == '0))
    else $error("ring not back at home slot");

endmodule : linear_convolution_fir
`default_nettype wire

>>> bench/linear_convolution_fir_tb.sv
// self-checking stream testbench of the linear convolution fir against its own convolution model
`timescale 1ns / 1ps
module linear_convolution_fir_tb;

  localparam int MAX_TAPS      = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int HIST_DEPTH    = MAX_TAPS - 1;
  localparam int IN_W          = ((lcf_pkg::TAP_IDX_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = MAX_TAPS + 8;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int RANDOM_BEATS  = 470;

  typedef struct packed {
    logic [lcf_pkg::SUM_W-1:0] sum;
    logic                      fin;
  } conv_out_t;

  logic                            clk;
  logic                            rst_n;
  logic [IN_W-1:0]                 in_tdata;   // tap_index, value, zero pad
  logic                            in_tuser;   // mode
  logic                            in_tlast;   // last sample
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lcf_pkg::SUM_W-1:0]       out_tdata;  // sum
  logic                            out_tlast;  // final_res
  logic                            out_tvalid;
  logic                            out_tready;
  logic                            cfg_we;
  logic [lcf_pkg::CFG_W-1:0]       cfg_wdata;

  logic                          idle_on;
  int                            stall_left;
  int                            cycle_count;
  int                            mismatches;
  int                            beats_sent;
  conv_out_t                     pending_sums[$];
  logic signed [SAMPLE_BITS-1:0] tap_model [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] history_model [HIST_DEPTH];
  logic [lcf_pkg::CFG_W-1:0]     tap_count_model;

  linear_convolution_fir #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned taps_in_use();
    if (tap_count_model == '0) return 32'd1;
    if (32'(tap_count_model) > MAX_TAPS) return 32'(MAX_TAPS);
    return 32'(tap_count_model);
  endfunction

  // one turn of the tap chain: exact sum over the active taps, then shift
  function automatic logic [lcf_pkg::SUM_W-1:0] shift_in_sample(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic signed [lcf_pkg::SUM_W-1:0] acc;
    logic signed [lcf_pkg::SUM_W-1:0] tap_w;
    logic signed [lcf_pkg::SUM_W-1:0] smp_w;
    int unsigned                      n;
    n     = taps_in_use();
    tap_w = tap_model[0];
    smp_w = s;
    acc   = tap_w * smp_w;
    for (int unsigned k = 1; k < n; k++) begin
      tap_w = tap_model[k];
      smp_w = history_model[k - 1];
      acc   = acc + tap_w * smp_w;
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) history_model[k] = history_model[k - 1];
    history_model[0] = s;
    return acc;
  endfunction

  function automatic void convolve_beat(input logic mode,
                                        input logic [lcf_pkg::TAP_IDX_W-1:0] idx,
                                        input logic [SAMPLE_BITS-1:0] val, input logic lst);
    int unsigned n;
    if (mode == lcf_pkg::MODE_TAP) begin
      tap_model[idx] = val;
      return;
    end
    n = taps_in_use();
    pending_sums.push_back({shift_in_sample(val), lst && n == 1});
    if (lst) begin
      // tail flush with zero samples, then the history starts over
      for (int unsigned k = 1; k < n; k++)
        pending_sums.push_back({shift_in_sample('0), k == n - 1});
      foreach (history_model[k]) history_model[k] = '0;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [lcf_pkg::CFG_W-1:0] pick_tap_count();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return lcf_pkg::CFG_W'($urandom_range(MAX_TAPS + 1, (1 << lcf_pkg::CFG_W) - 1));
      2, 3: return lcf_pkg::CFG_W'(MAX_TAPS);
      default: return lcf_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic send_beat(input logic mode, input logic [lcf_pkg::TAP_IDX_W-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] val, input logic lst);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tdata  <= IN_W'({val, idx});
    in_tuser  <= mode;
    in_tlast  <= lst;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    convolve_beat(mode, idx, val, lst);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    // a tap beat may still be in flight after the last sum
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tap_count(input logic [lcf_pkg::CFG_W-1:0] cnt);
    cfg_wdata <= cnt;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tap_count_model = cnt;
  endtask

  task automatic test_reset_state();
    // taps are zero and one tap is in use after reset
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd17, 16'h8000, 1'b1);
  endtask

  task automatic test_tap_count_extremes();
    wait_idle();
    set_tap_count('0);
    send_beat(lcf_pkg::MODE_TAP, 6'd0, 16'h8000, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h8000, 1'b1);
    wait_idle();
    set_tap_count('1);
    send_beat(lcf_pkg::MODE_TAP, 6'd63, 16'h8000, 1'b0);
    send_beat(lcf_pkg::MODE_TAP, 6'd1, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h8000, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h0001, 1'b1);
    wait_idle();
    set_tap_count(lcf_pkg::CFG_W'(MAX_TAPS));
    send_beat(lcf_pkg::MODE_TAP, 6'd62, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h8000, 1'b1);
    wait_idle();
    // a tap beyond the count must not contribute
    set_tap_count(lcf_pkg::CFG_W'(2));
    send_beat(lcf_pkg::MODE_TAP, 6'd5, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h7FFF, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h8000, 1'b1);
  endtask

  task automatic test_ignored_fields();
    // tlast on a tap beat and tap_index on a sample beat are don't-care
    send_beat(lcf_pkg::MODE_TAP, 6'd1, 16'h1234, 1'b1);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd63, 16'hABCD, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd21, 16'h4321, 1'b1);
  endtask

  task automatic test_tap_write_mid_sequence();
    wait_idle();
    set_tap_count(lcf_pkg::CFG_W'(3));
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h1000, 1'b0);
    send_beat(lcf_pkg::MODE_TAP, 6'd1, 16'hFFFB, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'h2000, 1'b0);
    send_beat(lcf_pkg::MODE_TAP, 6'd2, 16'h0007, 1'b0);
    send_beat(lcf_pkg::MODE_SAMPLE, 6'd0, 16'hC000, 1'b1);
  endtask

  task automatic test_random_sequences();
    int unsigned n;
    int unsigned len;
    while (beats_sent < RANDOM_BEATS) begin
      wait_idle();
      set_tap_count(pick_tap_count());
      n = taps_in_use();
      if ($urandom_range(0, 3) != 0) begin
        for (int unsigned k = 0; k < n; k++)
          send_beat(lcf_pkg::MODE_TAP, lcf_pkg::TAP_IDX_W'(k), rand_value(), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(lcf_pkg::MODE_TAP, lcf_pkg::TAP_IDX_W'($urandom), rand_value(),
                    1'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 20);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0)
            send_beat(lcf_pkg::MODE_TAP, lcf_pkg::TAP_IDX_W'($urandom), rand_value(),
                      1'($urandom));
          // most sequences close with tlast, some run on into the next one
          send_beat(lcf_pkg::MODE_SAMPLE, lcf_pkg::TAP_IDX_W'($urandom), rand_value(),
                    k == len - 1 && $urandom_range(0, 7) != 0);
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    wait_idle();
    set_tap_count(lcf_pkg::CFG_W'(4));
    for (int unsigned k = 0; k < 4; k++)
      send_beat(lcf_pkg::MODE_TAP, lcf_pkg::TAP_IDX_W'(k), rand_value(), 1'b0);
    repeat (2) begin
      for (int unsigned k = 0; k < 8; k++)
        send_beat(lcf_pkg::MODE_SAMPLE, lcf_pkg::TAP_IDX_W'($urandom), rand_value(), k == 7);
    end
  endtask

  // sink side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    conv_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected beat sum=%h last=%b", out_tdata, out_tlast));
      end else begin
        want = pending_sums.pop_front();
        if (out_tdata !== want.sum)
          report_mismatch($sformatf("sum got %h want %h", out_tdata, want.sum));
        if (out_tlast !== want.fin)
          report_mismatch($sformatf("final flag got %b want %b", out_tlast, want.fin));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      report_mismatch("cycle limit reached");
      $display("linear_convolution_fir_tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    idle_on     = 1'b1;
    stall_left  = 0;
    cycle_count = 0;
    mismatches  = 0;
    beats_sent  = 0;
    foreach (tap_model[k]) tap_model[k] = '0;
    foreach (history_model[k]) history_model[k] = '0;
    tap_count_model = lcf_pkg::CFG_W'(1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_tap_count_extremes();
    test_ignored_fields();
    test_tap_write_mid_sequence();
    test_random_sequences();
    test_back_to_back();
    wait_idle();
    if (mismatches == 0) begin
      $display("linear_convolution_fir_tb OK");
    end else begin
      $display("linear_convolution_fir_tb NOT OK");
    end
    $finish;
  end

endmodule
